// ----- rtl/sre_pkg.sv -----
// ============================================================================
// sre_pkg
// Shared types and constants of the segmented record encoder.
// ============================================================================
`default_nettype none

package sre_pkg;

	// Default format parameters.
	localparam int SEG_MAX_DEF  = 63;
	localparam int JOIN_BIT_DEF = 128;
	localparam int ARR_BIT_DEF  = 64;

	// Depth of the queue between the front and back parts.
	localparam int QUEUE_DEPTH = 4;

	// Most bytes that one item can produce.
	localparam int CMD_BYTES = 5;
	localparam int CMD_CNT_W = $clog2(CMD_BYTES + 1);

	typedef enum logic [1:0] {
		OP_INT    = 2'd0,
		OP_ARR    = 2'd1,
		OP_DSTART = 2'd2,
		OP_DBYTE  = 2'd3
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] value;
		logic [5:0]  array_len;
		logic [15:0] data_len;
		logic        join_req;
		logic [7:0]  data_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} out_item_t;

	// Byte-emission command: nbytes bytes, first byte in the top lane.
	typedef struct packed {
		logic [CMD_CNT_W-1:0]   nbytes;
		logic [CMD_BYTES*8-1:0] bytes;
	} cmd_t;

endpackage

`default_nettype wire

// ----- rtl/sre_front.sv -----
// ============================================================================
// sre_front
// Accepts items, tracks the blob segment state and builds byte commands.
// ============================================================================
`default_nettype none

module sre_front #(
	parameter int SEG_MAX  = sre_pkg::SEG_MAX_DEF,
	parameter int JOIN_BIT = sre_pkg::JOIN_BIT_DEF,
	parameter int ARR_BIT  = sre_pkg::ARR_BIT_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_ready,
	input  wire sre_pkg::in_item_t item,
	input  wire logic             queue_full,
	output logic                  push,
	output sre_pkg::cmd_t         cmd
);

	localparam int SEG_W = $clog2(SEG_MAX + 1);
	localparam logic [SEG_W-1:0] SEG_MAX_S = SEG_W'(SEG_MAX);
	localparam logic [15:0]      SEG_MAX_T = 16'(SEG_MAX);
	localparam logic [7:0]       SEG_MAX_B = 8'(SEG_MAX);
	localparam logic [7:0]       JOIN_B    = 8'(JOIN_BIT);
	localparam logic [7:0]       ARR_B     = 8'(ARR_BIT);

	logic [15:0]      total_q, total_d;
	logic [SEG_W-1:0] seg_q, seg_d;
	logic             fj_q, fj_d;
	logic             in_blob_q, in_blob_d;

	logic             accept;
	logic [15:0]      tot_src;
	logic             hdr_fj;
	logic [7:0]       hdr;
	logic [SEG_W-1:0] hdr_seg;
	logic [15:0]      tot_dec;
	logic [SEG_W-1:0] seg_dec;
	logic [7:0]       alen_sat;
	logic             emit;

	assign item_ready = !queue_full;
	assign accept     = item_valid && item_ready;

	assign tot_dec = total_q - 16'd1;
	assign seg_dec = (seg_q == '0) ? '0 : seg_q - SEG_W'(1);

	// Segment header for a remaining length: a final header carries the length,
	// a full one is always joined.
	always_comb begin
		if (item.op == sre_pkg::OP_DSTART) begin
			tot_src = item.data_len;
			hdr_fj  = item.join_req;
		end else begin
			tot_src = tot_dec;
			hdr_fj  = fj_q;
		end
		if (tot_src <= SEG_MAX_T) begin
			hdr     = (hdr_fj ? JOIN_B : 8'd0) | tot_src[7:0];
			hdr_seg = SEG_W'(tot_src);
		end else begin
			hdr     = JOIN_B | SEG_MAX_B;
			hdr_seg = SEG_MAX_S;
		end
	end

	assign alen_sat = (8'(item.array_len) > SEG_MAX_B) ? SEG_MAX_B : 8'(item.array_len);

	always_comb begin
		total_d   = total_q;
		seg_d     = seg_q;
		fj_d      = fj_q;
		in_blob_d = in_blob_q;
		emit      = 1'b1;
		cmd       = '0;
		case (item.op)
			sre_pkg::OP_INT: begin
				total_d   = '0;
				seg_d     = '0;
				fj_d      = 1'b0;
				in_blob_d = 1'b0;
				if (item.value[31:24] != 8'd0) begin
					cmd.nbytes = sre_pkg::CMD_CNT_W'(5);
					cmd.bytes  = {8'd4, item.value};
				end else if (item.value[23:16] != 8'd0) begin
					cmd.nbytes = sre_pkg::CMD_CNT_W'(4);
					cmd.bytes  = {8'd3, item.value[23:0], 8'd0};
				end else if (item.value[15:8] != 8'd0) begin
					cmd.nbytes = sre_pkg::CMD_CNT_W'(3);
					cmd.bytes  = {8'd2, item.value[15:0], 16'd0};
				end else if (item.value[7:0] != 8'd0) begin
					cmd.nbytes = sre_pkg::CMD_CNT_W'(2);
					cmd.bytes  = {8'd1, item.value[7:0], 24'd0};
				end else begin
					cmd.nbytes = sre_pkg::CMD_CNT_W'(1);
					cmd.bytes  = '0;
				end
			end
			sre_pkg::OP_ARR: begin
				total_d    = '0;
				seg_d      = '0;
				fj_d       = 1'b0;
				in_blob_d  = 1'b0;
				cmd.nbytes = sre_pkg::CMD_CNT_W'(1);
				cmd.bytes  = {ARR_B | alen_sat | (item.join_req ? JOIN_B : 8'd0), 32'd0};
			end
			sre_pkg::OP_DSTART: begin
				total_d    = item.data_len;
				fj_d       = item.join_req;
				seg_d      = hdr_seg;
				in_blob_d  = (item.data_len != 16'd0);
				cmd.nbytes = sre_pkg::CMD_CNT_W'(1);
				cmd.bytes  = {hdr, 32'd0};
			end
			sre_pkg::OP_DBYTE: begin
				if (!in_blob_q) begin
					emit = 1'b0;
				end else if (tot_dec == 16'd0) begin
					total_d    = '0;
					seg_d      = '0;
					fj_d       = 1'b0;
					in_blob_d  = 1'b0;
					cmd.nbytes = sre_pkg::CMD_CNT_W'(1);
					cmd.bytes  = {item.data_byte, 32'd0};
				end else if (seg_dec == '0) begin
					total_d    = tot_dec;
					seg_d      = hdr_seg;
					cmd.nbytes = sre_pkg::CMD_CNT_W'(2);
					cmd.bytes  = {item.data_byte, hdr, 24'd0};
				end else begin
					total_d    = tot_dec;
					seg_d      = seg_dec;
					cmd.nbytes = sre_pkg::CMD_CNT_W'(1);
					cmd.bytes  = {item.data_byte, 32'd0};
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	assign push = accept && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q   <= '0;
			seg_q     <= '0;
			fj_q      <= 1'b0;
			in_blob_q <= 1'b0;
		end else if (accept) begin
			total_q   <= total_d;
			seg_q     <= seg_d;
			fj_q      <= fj_d;
			in_blob_q <= in_blob_d;
		end
	end

	// An idle blob holds no counts; an open blob always expects a byte.
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!in_blob_q |-> (total_q == 16'd0 && seg_q == '0))
		else $error("idle blob holds nonzero counters");
	a_open_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		in_blob_q |-> (total_q != 16'd0 && seg_q != '0))
		else $error("open blob with nothing left");

endmodule

`default_nettype wire

// ----- rtl/sre_queue.sv -----
// ============================================================================
// sre_queue
// Short first-in first-out queue of byte commands between front and back.
// ============================================================================
`default_nettype none

module sre_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire sre_pkg::cmd_t cmd_in,
	output logic               full,
	input  wire logic          pop,
	output sre_pkg::cmd_t      cmd_out,
	output logic               empty
);

	localparam int DEPTH = sre_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	sre_pkg::cmd_t    mem_q [DEPTH];
	logic [PTR_W-1:0] wp_q, rp_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign cmd_out = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == PTR_W'(DEPTH - 1)) ? '0 : wp_q + PTR_W'(1);
			end
			if (do_pop) begin
				rp_q <= (rp_q == PTR_W'(DEPTH - 1)) ? '0 : rp_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("command pushed into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("command popped from an empty queue");

endmodule

`default_nettype wire

// ----- rtl/sre_back.sv -----
// ============================================================================
// sre_back
// Unpacks byte commands into the output byte stream, one byte per cycle while the output is ready.
// ============================================================================
`default_nettype none

module sre_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          queue_empty,
	input  wire sre_pkg::cmd_t cmd,
	output logic               pop,
	output logic               result_valid,
	input  wire logic          result_ready,
	output sre_pkg::out_item_t result
);

	localparam int CW = sre_pkg::CMD_CNT_W;
	localparam int BW = sre_pkg::CMD_BYTES * 8;

	logic [CW-1:0] cnt_q;
	logic [BW-1:0] sh_q;
	logic          take;

	assign result_valid    = (cnt_q != '0);
	assign result.out_byte = sh_q[BW-1 -: 8];
	assign result.last     = (cnt_q == CW'(1));
	assign take            = result_valid && result_ready;
	assign pop             = !queue_empty && ((cnt_q == '0) || (take && cnt_q == CW'(1)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (pop) begin
			cnt_q <= cmd.nbytes;
		end else if (take) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			sh_q <= cmd.bytes;
		end else if (take) begin
			sh_q <= {sh_q[BW-9:0], 8'd0};
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(sre_pkg::CMD_BYTES))
		else $error("byte count beyond command size");

endmodule

`default_nettype wire

// ----- rtl/segmented_record_encoder.sv -----
// ============================================================================
// segmented_record_encoder
// Serializes integer, array and data-blob items into a compact byte format.
// ============================================================================
// Each accepted item turns into at most five output bytes: an integer gives a
// length byte and up to four big-endian value bytes (zero gives one byte 0),
// an array gives one header byte, a data start gives the first segment header,
// and a data byte passes through, followed by the next segment header when a
// full segment ends with more data to come. A data byte outside a blob is
// taken and produces nothing. The front part takes one item per cycle while
// its four-entry command queue has room; the back part drives one byte per
// cycle from its output register. Sustained throughput is therefore set by the
// output byte port and by how many bytes an item produces (one for a plain
// data byte, two at a segment boundary, up to five for an integer). When the
// block is idle, an accepted item's command is first written into the queue,
// then loaded from the queue head into the back part's output register, which
// offers its first byte. Back-pressure on the output stalls the back part
// only; the front keeps accepting items until the queue fills.
// ============================================================================
`default_nettype none

module segmented_record_encoder #(
	parameter int SEG_MAX  = sre_pkg::SEG_MAX_DEF,
	parameter int JOIN_BIT = sre_pkg::JOIN_BIT_DEF,
	parameter int ARR_BIT  = sre_pkg::ARR_BIT_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_ready,
	input  wire sre_pkg::in_item_t  item,
	output logic                    result_valid,
	input  wire logic               result_ready,
	output sre_pkg::out_item_t      result
);

	// Command from the front part into the queue.
	sre_pkg::cmd_t front_cmd;
	logic          front_push;
	logic          queue_full;

	// Command from the queue head into the back part.
	sre_pkg::cmd_t head_cmd;
	logic          queue_empty;
	logic          back_pop;

	// The front part classifies each item and keeps the blob counters, so an
	// item's bytes are fully decided the cycle it is accepted.
	sre_front #(
		.SEG_MAX  (SEG_MAX),
		.JOIN_BIT (JOIN_BIT),
		.ARR_BIT  (ARR_BIT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.queue_full (queue_full),
		.push       (front_push),
		.cmd        (front_cmd)
	);

	// The queue lets the front run ahead while the output is stalled.
	sre_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (front_push),
		.cmd_in  (front_cmd),
		.full    (queue_full),
		.pop     (back_pop),
		.cmd_out (head_cmd),
		.empty   (queue_empty)
	);

	// The back part shifts a command's bytes out, marking the final one, and
	// reloads in the same cycle its last byte is taken.
	sre_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.queue_empty  (queue_empty),
		.cmd          (head_cmd),
		.pop          (back_pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

`default_nettype wire

// ----- sim/tb_segmented_record_encoder.sv -----
// ============================================================================
// tb_segmented_record_encoder
// Self-checking testbench for the segmented record encoder.
// ============================================================================
// A queue of pending items is filled up front. It starts with a short directed
// list covering integer sizes, array headers, empty blobs, stray data bytes and
// blobs that are cut short. Random traffic follows, mostly well-formed blobs.
// A clocked driver presents the items and a clocked monitor collects the
// output bytes. Every accepted item runs through a behavioral encoder that
// keeps its own blob state and queues the bytes the block should emit.
// ============================================================================
`default_nettype none

module tb_segmented_record_encoder;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SEG_MAX    = sre_pkg::SEG_MAX_DEF;
	localparam int JOIN_BIT   = sre_pkg::JOIN_BIT_DEF;
	localparam int ARR_BIT    = sre_pkg::ARR_BIT_DEF;
	localparam int RANDOM_ITEMS = 360;
	localparam int CYCLE_LIMIT  = 400000;
	// Idling stops once this few items are still waiting to be sent.
	localparam int CALM_TAIL    = 50;
	// Receiver hold-off long enough to fill the internal command queue.
	localparam int HOLD_CYCLES  = 300;
	localparam int HOLD_AFTER   = 100;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               item_valid = 1'b0;
	logic               item_ready;
	sre_pkg::in_item_t  item = '0;
	logic               result_valid;
	logic               result_ready = 1'b0;
	sre_pkg::out_item_t result;

	segmented_record_encoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always #5 clk = ~clk;

	sre_pkg::in_item_t  pending_items[$];
	sre_pkg::out_item_t expected_bytes[$];
	int        random_cnt = 0;
	int        accepted_cnt = 0;
	int        checked_cnt = 0;
	int        fail_cnt = 0;
	int        cycle_cnt = 0;

	// Blob state of the behavioral encoder.
	logic [15:0] blob_left = '0;
	logic [5:0]  seg_left = '0;
	logic        blob_join = 1'b0;
	logic        blob_open = 1'b0;

	// ------------------------------------------------------------------------
	// Behavioral encoder
	// ------------------------------------------------------------------------

	task automatic expect_byte(logic [7:0] b, logic last);
		sre_pkg::out_item_t r;
		r.out_byte = b;
		r.last = last;
		expected_bytes.push_back(r);
	endtask

	// Header of the next segment: a full joined segment while more than one
	// segment's worth remains, otherwise the remaining count with the join flag
	// that was requested for the end of the blob.
	function automatic logic [7:0] seg_header();
		if (blob_left <= SEG_MAX) begin
			seg_left = 6'(blob_left);
			return 8'((blob_join ? JOIN_BIT : 0) | blob_left);
		end
		seg_left = 6'(SEG_MAX);
		return 8'(JOIN_BIT | SEG_MAX);
	endfunction

	task automatic encode_item(sre_pkg::in_item_t it);
		logic [2:0] nb;
		int         alen;
		case (it.op)
			sre_pkg::OP_INT: begin
				// An integer or array header abandons any blob in progress.
				blob_left = '0;
				seg_left = '0;
				blob_join = 1'b0;
				blob_open = 1'b0;
				if (it.value == 32'd0) begin
					expect_byte(8'd0, 1'b1);
				end else begin
					nb = (it.value > 32'hFF_FFFF) ? 3'd4 :
						(it.value > 32'hFFFF) ? 3'd3 :
						(it.value > 32'hFF) ? 3'd2 : 3'd1;
					expect_byte(8'(nb), 1'b0);
					for (int i = int'(nb) - 1; i >= 0; i--)
						expect_byte(it.value[8*i +: 8], i == 0);
				end
			end
			sre_pkg::OP_ARR: begin
				blob_left = '0;
				seg_left = '0;
				blob_join = 1'b0;
				blob_open = 1'b0;
				alen = (it.array_len > SEG_MAX) ? SEG_MAX : int'(it.array_len);
				expect_byte(8'(ARR_BIT | (it.join_req ? JOIN_BIT : 0) | alen), 1'b1);
			end
			sre_pkg::OP_DSTART: begin
				// A new start replaces any blob in progress; an empty blob
				// emits its header and leaves the encoder idle.
				blob_left = it.data_len;
				blob_join = it.join_req;
				expect_byte(seg_header(), 1'b1);
				blob_open = (it.data_len != 16'd0);
			end
			sre_pkg::OP_DBYTE: begin
				// Data bytes outside a blob are swallowed without output.
				if (blob_open) begin
					blob_left = blob_left - 16'd1;
					seg_left = (seg_left == 6'd0) ? 6'd0 : seg_left - 6'd1;
					if (blob_left == 16'd0) begin
						blob_left = '0;
						seg_left = '0;
						blob_join = 1'b0;
						blob_open = 1'b0;
						expect_byte(it.data_byte, 1'b1);
					end else if (seg_left == 6'd0) begin
						expect_byte(it.data_byte, 1'b0);
						expect_byte(seg_header(), 1'b1);
					end else begin
						expect_byte(it.data_byte, 1'b1);
					end
				end
			end
			default: begin
			end
		endcase
	endtask

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	// Fields that the operation does not use carry random values too.
	function automatic sre_pkg::in_item_t noise_item(sre_pkg::op_t op);
		sre_pkg::in_item_t it;
		it.op = op;
		it.value = $urandom;
		it.array_len = 6'($urandom);
		it.data_len = 16'($urandom);
		it.join_req = 1'($urandom);
		it.data_byte = 8'($urandom);
		return it;
	endfunction

	task automatic push_int(logic [31:0] v);
		sre_pkg::in_item_t it;
		it = noise_item(sre_pkg::OP_INT);
		it.value = v;
		pending_items.push_back(it);
		random_cnt++;
	endtask

	task automatic push_arr(logic [5:0] len, logic j);
		sre_pkg::in_item_t it;
		it = noise_item(sre_pkg::OP_ARR);
		it.array_len = len;
		it.join_req = j;
		pending_items.push_back(it);
		random_cnt++;
	endtask

	task automatic push_start(logic [15:0] len, logic j);
		sre_pkg::in_item_t it;
		it = noise_item(sre_pkg::OP_DSTART);
		it.data_len = len;
		it.join_req = j;
		pending_items.push_back(it);
		random_cnt++;
	endtask

	task automatic push_byte(logic [7:0] b);
		sre_pkg::in_item_t it;
		it = noise_item(sre_pkg::OP_DBYTE);
		it.data_byte = b;
		pending_items.push_back(it);
		random_cnt++;
	endtask

	// Both sides idle only in some windows of the run and never near its end.
	function automatic bit idling_ok();
		return pending_items.size() > CALM_TAIL && (accepted_cnt % 90) < 60;
	endfunction

	task automatic report_failure(string msg);
		if (fail_cnt < 10)
			$display("mismatch: %s", msg);
		fail_cnt++;
	endtask

	// ------------------------------------------------------------------------
	// Driver: presents pending items and feeds accepted ones to the encoder.
	// ------------------------------------------------------------------------

	int send_gap = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
			send_gap <= 0;
		end else begin
			if (item_valid && item_ready) begin
				encode_item(item);
				accepted_cnt <= accepted_cnt + 1;
			end
			// The current item stays on the bus until it is taken.
			if (!item_valid || item_ready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					item_valid <= 1'b0;
				end else if (idling_ok() && $urandom_range(0, 9) == 0) begin
					send_gap <= $urandom_range(1, 17) - 1;
					item_valid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					item <= pending_items.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: checks output bytes and paces the output with its ready.
	// ------------------------------------------------------------------------

	int                 stall_left = 0;
	int                 hold_left = 0;
	bit                 hold_done = 1'b0;
	sre_pkg::out_item_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			stall_left <= 0;
			hold_left <= 0;
		end else begin
			if (result_valid && result_ready) begin
				checked_cnt <= checked_cnt + 1;
				if (expected_bytes.size() == 0) begin
					report_failure($sformatf("unexpected byte %02h last %0b",
						result.out_byte, result.last));
				end else begin
					want = expected_bytes.pop_front();
					if (result.out_byte !== want.out_byte)
						report_failure($sformatf("byte %0d: out_byte exp %02h got %02h",
							checked_cnt, want.out_byte, result.out_byte));
					if (result.last !== want.last)
						report_failure($sformatf("byte %0d: last exp %0b got %0b",
							checked_cnt, want.last, result.last));
				end
			end
			// One long hold-off lets the block fill up and stall its input
			// while the driver keeps offering items.
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				result_ready <= 1'b0;
			end else if (!hold_done && checked_cnt >= HOLD_AFTER) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_CYCLES - 1;
				result_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				result_ready <= 1'b0;
			end else if (idling_ok() && $urandom_range(0, 7) == 0) begin
				stall_left <= $urandom_range(1, 17) - 1;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------------

	initial begin
		int                pick;
		int                len;
		int                cut;
		sre_pkg::in_item_t it;

		// Integers at every size boundary, zero included.
		push_int(32'd0);
		push_int(32'd1);
		push_int(32'hFF);
		push_int(32'h100);
		push_int(32'hFFFF);
		push_int(32'h1_0000);
		push_int(32'hFF_FFFF);
		push_int(32'h100_0000);
		push_int(32'hFFFF_FFFF);
		// Array headers at both ends of the length range. The length field
		// cannot exceed the segment maximum, so saturation never triggers.
		push_arr(6'd0, 1'b0);
		push_arr(6'd63, 1'b1);
		// Empty blobs, with and without the join flag.
		push_start(16'd0, 1'b0);
		push_start(16'd0, 1'b1);
		// A data byte with no blob open is swallowed.
		pending_items.push_back(noise_item(sre_pkg::OP_DBYTE));
		push_start(16'd2, 1'b1);
		push_byte(8'h00);
		push_byte(8'hFF);
		// Exactly one full segment, then starts that restart the blob.
		push_start(16'd63, 1'b1);
		push_start(16'd64, 1'b0);
		push_start(16'hFFFF, 1'b1);
		push_byte(8'h5A);
		// An integer abandons the blob; the byte after it is stray.
		push_int(32'd7);
		pending_items.push_back(noise_item(sre_pkg::OP_DBYTE));
		push_start(16'd3, 1'b0);
		push_byte(8'hC3);
		push_start(16'd1, 1'b1);
		push_byte(8'h81);

		// A blob whose last segment is exactly full: no header after it.
		push_start(16'd126, 1'($urandom));
		for (int k = 0; k < 126; k++)
			push_byte(8'($urandom));

		while (random_cnt < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				// Well-formed blob, now and then cut short.
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: len = $urandom_range(1, 12);
					6, 7, 8:          len = $urandom_range(60, 130);
					default:          len = $urandom_range(0, 3);
				endcase
				cut = ($urandom_range(0, 99) < 15) ? $urandom_range(0, len) : len;
				push_start(16'(len), 1'($urandom));
				// The last blob is trimmed so the run keeps its item count.
				if (cut > RANDOM_ITEMS - random_cnt)
					cut = RANDOM_ITEMS - random_cnt;
				for (int k = 0; k < cut; k++)
					push_byte(8'($urandom));
			end else if (pick < 75) begin
				push_int(32'($urandom) >> (8 * $urandom_range(0, 4)));
			end else if (pick < 87) begin
				push_arr(6'($urandom), 1'($urandom));
			end else if (pick < 93) begin
				pending_items.push_back(noise_item(sre_pkg::OP_DBYTE));
				random_cnt++;
			end else begin
				// Start with a length anywhere in range, abandoned early.
				it = noise_item(sre_pkg::OP_DSTART);
				pending_items.push_back(it);
				random_cnt++;
				for (int k = $urandom_range(0, 3); k > 0; k--)
					push_byte(8'($urandom));
			end
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() != 0 || item_valid || expected_bytes.size() != 0)
			@(posedge clk);
		// Let any stray output that should not exist show up.
		repeat (20) @(posedge clk);

		if (fail_cnt == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ----- segmented_record_encoder.f -----
rtl/sre_pkg.sv
rtl/sre_front.sv
rtl/sre_queue.sv
rtl/sre_back.sv
rtl/segmented_record_encoder.sv
sim/tb_segmented_record_encoder.sv
